// ===== rtl/core/mdd_pkg.sv =====
// Package with the shared constants, types and helpers of the dominated difference core.
`timescale 1ns / 1ps

package mdd_pkg;

  // Largest matrix side that the row store holds.
  localparam int MAX_SIZE = 64;
  localparam int ADDR_W   = $clog2(MAX_SIZE);
  localparam int SIZE_W   = ADDR_W + 1;

  // Fixed field widths.
  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;
  localparam int DIFF_W = DATA_W + 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(5);

  // Best difference before any pair is seen: the most negative 33-bit value.
  localparam logic signed [DIFF_W-1:0] BEST_RESET = {1'b1, {(DIFF_W-1){1'b0}}};

  // One element on its way from the scan stage to the update stage.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
    logic [ADDR_W-1:0] col;
    logic              first_row;
    logic              first_col;
    logic              last;
    logic              single;
  } stage_t;

  // Matrix side in use: zero counts as one, anything above the store depth is clamped.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] size);
    logic [SIZE_W-1:0] n;
    if (size == '0) begin
      n = SIZE_W'(1);
    end else if (32'(size) > MAX_SIZE) begin
      n = SIZE_W'(MAX_SIZE);
    end else begin
      n = SIZE_W'(size);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/matrix_max_dominated_difference_core.sv =====
// Top level of the maximum dominated difference core.
//
// Usage: the elements of an N by N matrix arrive on the in_ channel, one
// signed 32-bit element per transfer, in row-major order. After the last
// element of each matrix one result leaves on the out_ channel: the largest
// mat(c,d) - mat(a,b) with c > a and d > b as a 33-bit signed value, and
// out_no_pair set when N is one (the difference then reads zero).
// N is written through cfg_wr_en / cfg_wr_data while the core is idle; a
// write restarts the matrix. Zero counts as one, sizes above 64 as 64.
// Throughput: one element per cycle while in_stall is low. Each element
// passes a scan stage that reads its column of the row store and an update
// stage that writes it back and loads the result register at matrix end.
// The in_ channel stalls only when a matrix ends while the previous result
// is still held by a stalled receiver.
// Reset (synchronous, rst_n low) sets N to 5 and empties the pipeline; the
// row store needs no clearing since row zero always writes an entry before
// any later row reads it.
`timescale 1ns / 1ps

module matrix_max_dominated_difference_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mdd_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mdd_pkg::DATA_W-1:0]       in_element_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mdd_pkg::DIFF_W-1:0]       out_best_difference,
  output logic                             out_no_pair
);

  mdd_pkg::stage_t            stage;
  logic                       adv;
  logic                       rd_en;
  logic [mdd_pkg::ADDR_W-1:0] rd_addr;
  logic [mdd_pkg::DATA_W-1:0] rd_data;
  logic                       wr_en;
  logic [mdd_pkg::ADDR_W-1:0] wr_addr;
  logic [mdd_pkg::DATA_W-1:0] wr_data;

  // Counters and store read.
  mdd_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_value    (in_element_value),
    .in_stall    (in_stall),
    .adv         (adv),
    .stage_r     (stage),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr)
  );

  // Row store of prefix minima.
  mdd_row_mem u_row_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data)
  );

  // Read-modify-write of the store and the result register.
  mdd_update u_update (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .stage_r             (stage),
    .rd_data             (rd_data),
    .adv                 (adv),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_best_difference (out_best_difference),
    .out_no_pair         (out_no_pair)
  );

endmodule

// ===== rtl/core/mdd_row_mem.sv =====
// Row store of prefix minima: one write port and one registered read port.
`timescale 1ns / 1ps

module mdd_row_mem (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [mdd_pkg::ADDR_W-1:0]       wr_addr,
  input  logic [mdd_pkg::DATA_W-1:0]       wr_data,
  input  logic                             rd_en,
  input  logic [mdd_pkg::ADDR_W-1:0]       rd_addr,
  output logic [mdd_pkg::DATA_W-1:0]       rd_data_r
);

  logic [mdd_pkg::DATA_W-1:0] mem [mdd_pkg::MAX_SIZE];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mdd_scan.sv =====
// Input stage: size register, row and column counters, and the store read request.
`timescale 1ns / 1ps

module mdd_scan (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [mdd_pkg::CFG_W-1:0]        cfg_wr_data,
  input  logic                             in_valid,
  input  logic [mdd_pkg::DATA_W-1:0]       in_value,
  output logic                             in_stall,
  input  logic                             adv,
  output mdd_pkg::stage_t                  stage_r,
  output logic                             rd_en,
  output logic [mdd_pkg::ADDR_W-1:0]       rd_addr
);

  logic [mdd_pkg::CFG_W-1:0]  size_r;
  logic [mdd_pkg::ADDR_W-1:0] row_r, row_nxt;
  logic [mdd_pkg::ADDR_W-1:0] col_r, col_nxt;
  logic [mdd_pkg::SIZE_W-1:0] n;
  logic                       col_end, row_end;
  logic                       accept;
  mdd_pkg::stage_t            stage_nxt;

  // The stage holds only while its element cannot move on.
  assign in_stall = stage_r.valid && !adv;
  assign accept   = in_valid && !in_stall;

  assign n       = mdd_pkg::eff_size(size_r);
  assign col_end = ({1'b0, col_r} + mdd_pkg::SIZE_W'(1)) == n;
  assign row_end = ({1'b0, row_r} + mdd_pkg::SIZE_W'(1)) == n;

  // The store entry of this column is fetched as the element is taken in.
  assign rd_en   = accept;
  assign rd_addr = col_r;

  // Next position in row-major order.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_wr_en) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + mdd_pkg::ADDR_W'(1);
      end else begin
        col_nxt = col_r + mdd_pkg::ADDR_W'(1);
      end
    end
  end

  // Stage register contents.
  always_comb begin
    stage_nxt = stage_r;
    if (accept) begin
      stage_nxt.valid     = 1'b1;
      stage_nxt.value     = in_value;
      stage_nxt.col       = col_r;
      stage_nxt.first_row = (row_r == '0);
      stage_nxt.first_col = (col_r == '0);
      stage_nxt.last      = col_end && row_end;
      stage_nxt.single    = (n < mdd_pkg::SIZE_W'(2));
    end else if (adv) begin
      stage_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r        <= mdd_pkg::SIZE_RESET;
      row_r         <= '0;
      col_r         <= '0;
      stage_r.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      stage_r.valid <= stage_nxt.valid;
    end
    // Payload fields need no reset.
    stage_r.value     <= stage_nxt.value;
    stage_r.col       <= stage_nxt.col;
    stage_r.first_row <= stage_nxt.first_row;
    stage_r.first_col <= stage_nxt.first_col;
    stage_r.last      <= stage_nxt.last;
    stage_r.single    <= stage_nxt.single;
  end

endmodule

// ===== rtl/core/mdd_update.sv =====
// Update stage: running minima, best difference, store write-back and result register.
`timescale 1ns / 1ps

module mdd_update (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  mdd_pkg::stage_t                  stage_r,
  input  logic [mdd_pkg::DATA_W-1:0]       rd_data,
  output logic                             adv,
  output logic                             wr_en,
  output logic [mdd_pkg::ADDR_W-1:0]       wr_addr,
  output logic [mdd_pkg::DATA_W-1:0]       wr_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mdd_pkg::DIFF_W-1:0]       out_best_difference,
  output logic                             out_no_pair
);

  logic signed [mdd_pkg::DATA_W-1:0] left_min_r, left_min_nxt;
  logic signed [mdd_pkg::DATA_W-1:0] diag_min_r, diag_min_nxt;
  logic signed [mdd_pkg::DIFF_W-1:0] best_r, best_nxt;
  logic signed [mdd_pkg::DIFF_W-1:0] best_upd;
  logic signed [mdd_pkg::DIFF_W-1:0] cand;
  logic signed [mdd_pkg::DATA_W-1:0] x, old, rowmin;
  logic                              go, load;
  logic                              out_valid_r, out_valid_nxt;
  logic [mdd_pkg::DIFF_W-1:0]        out_diff_r;
  logic                              out_no_pair_r;

  // The element moves on unless it ends a matrix while the result register is blocked.
  assign adv  = !(stage_r.last && out_valid_r && out_stall);
  assign go   = stage_r.valid && adv;
  assign load = go && stage_r.last;

  assign x   = $signed(stage_r.value);
  assign old = $signed(rd_data);

  // Difference against the minimum of the rectangle above and to the left.
  assign cand     = {x[mdd_pkg::DATA_W-1], x} - {diag_min_r[mdd_pkg::DATA_W-1], diag_min_r};
  assign best_upd = (!stage_r.first_row && !stage_r.first_col && (cand > best_r)) ?
                    cand : best_r;

  // Running minimum of the current row, and the store entry refresh.
  assign rowmin  = (stage_r.first_col || (x < left_min_r)) ? x : left_min_r;
  assign wr_en   = go && (stage_r.first_row || (rowmin < old));
  assign wr_addr = stage_r.col;
  assign wr_data = rowmin;

  // Next values of the running state; a matrix end or a size write starts over.
  always_comb begin
    left_min_nxt = left_min_r;
    diag_min_nxt = diag_min_r;
    best_nxt     = best_r;
    if (cfg_wr_en || load) begin
      left_min_nxt = '0;
      diag_min_nxt = '0;
      best_nxt     = mdd_pkg::BEST_RESET;
    end else if (go) begin
      left_min_nxt = rowmin;
      diag_min_nxt = stage_r.first_row ? diag_min_r : old;
      best_nxt     = best_upd;
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_min_r  <= '0;
      diag_min_r  <= '0;
      best_r      <= mdd_pkg::BEST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      left_min_r  <= left_min_nxt;
      diag_min_r  <= diag_min_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, loaded once per matrix.
  always_ff @(posedge clk) begin
    if (load) begin
      out_diff_r    <= stage_r.single ? '0 : best_upd;
      out_no_pair_r <= stage_r.single;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_best_difference = out_diff_r;
  assign out_no_pair         = out_no_pair_r;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the maximum dominated difference core.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 1250;

  localparam logic [mdd_pkg::DATA_W-1:0] ELEM_MIN = 32'h8000_0000;
  localparam logic [mdd_pkg::DATA_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;

  // One expected matrix result.
  typedef struct packed {
    logic signed [mdd_pkg::DIFF_W-1:0] diff;
    logic                              no_pair;
  } matrix_result_t;

  // Tracks the matrix scan and holds the results still to come out of the core.
  class dominated_diff_scoreboard;
    logic [mdd_pkg::CFG_W-1:0]         side_cfg;
    logic signed [mdd_pkg::DATA_W-1:0] col_min [mdd_pkg::MAX_SIZE];
    logic signed [mdd_pkg::DATA_W-1:0] run_min;
    logic signed [mdd_pkg::DATA_W-1:0] corner_min;
    int unsigned                       row_idx;
    int unsigned                       col_idx;
    logic signed [mdd_pkg::DIFF_W-1:0] best;
    matrix_result_t                    expected_q[$];
    int                                failures;

    function new();
      side_cfg = mdd_pkg::SIZE_RESET;
      failures = 0;
      foreach (col_min[i]) col_min[i] = '0;
      restart_matrix();
    endfunction

    function void restart_matrix();
      row_idx    = 0;
      col_idx    = 0;
      run_min    = '0;
      corner_min = '0;
      best       = {1'b1, {(mdd_pkg::DIFF_W-1){1'b0}}};
    endfunction

    // Matrix side in use: zero counts as one, large values clamp to the store depth.
    function int unsigned side();
      if (side_cfg == '0) begin
        return 1;
      end
      if (int'(side_cfg) > mdd_pkg::MAX_SIZE) begin
        return mdd_pkg::MAX_SIZE;
      end
      return int'(side_cfg);
    endfunction

    function void write_size(logic [mdd_pkg::CFG_W-1:0] value);
      side_cfg = value;
      restart_matrix();
    endfunction

    // Folds one accepted element into the scan and queues a result at matrix end.
    function void note_element(logic signed [mdd_pkg::DATA_W-1:0] x);
      int unsigned                       n;
      logic signed [mdd_pkg::DATA_W-1:0] prev;
      logic signed [mdd_pkg::DATA_W-1:0] prefix;
      logic signed [mdd_pkg::DIFF_W-1:0] cand;
      matrix_result_t                    res;
      n = side();
      if (row_idx >= n || col_idx >= n) begin
        restart_matrix();
      end
      if (row_idx > 0 && col_idx > 0) begin
        cand = $signed({x[mdd_pkg::DATA_W-1], x})
               - $signed({corner_min[mdd_pkg::DATA_W-1], corner_min});
        if (cand > best) begin
          best = cand;
        end
      end
      prev = col_min[col_idx];
      if (row_idx > 0) begin
        corner_min = prev;
      end
      prefix  = (col_idx == 0 || x < run_min) ? x : run_min;
      run_min = prefix;
      if (row_idx == 0 || prefix < prev) begin
        col_min[col_idx] = prefix;
      end
      if (col_idx + 1 < n) begin
        col_idx++;
        return;
      end
      col_idx = 0;
      if (row_idx + 1 < n) begin
        row_idx++;
        return;
      end
      if (n < 2) begin
        res.diff    = '0;
        res.no_pair = 1'b1;
      end else begin
        res.diff    = best;
        res.no_pair = 1'b0;
      end
      expected_q.push_back(res);
      restart_matrix();
    endfunction

    // Compares one result transfer with the oldest expected result.
    function void check_result(logic [mdd_pkg::DIFF_W-1:0] diff, logic no_pair);
      matrix_result_t res;
      if (expected_q.size() == 0) begin
        $error("unexpected result: best_difference %0d, no_pair %0b", $signed(diff), no_pair);
        failures++;
        return;
      end
      res = expected_q.pop_front();
      if (diff !== res.diff) begin
        $error("best_difference mismatch: expected %0d, actual %0d",
               $signed(res.diff), $signed(diff));
        failures++;
      end
      if (no_pair !== res.no_pair) begin
        $error("no_pair mismatch: expected %0b, actual %0b", res.no_pair, no_pair);
        failures++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [mdd_pkg::CFG_W-1:0]   cfg_wr_data;
  logic                        in_valid;
  logic                        in_stall;
  logic [mdd_pkg::DATA_W-1:0]  in_element_value;
  logic                        out_valid;
  logic                        out_stall;
  logic [mdd_pkg::DIFF_W-1:0]  out_best_difference;
  logic                        out_no_pair;

  dominated_diff_scoreboard sb = new();

  bit in_gaps_on;
  bit out_gaps_on;
  int idle_cycles = 0;

  matrix_max_dominated_difference_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_element_value    (in_element_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_best_difference (out_best_difference),
    .out_no_pair         (out_no_pair)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Observe every transfer and register write at the rising edge; also run the watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) begin
        sb.write_size(cfg_wr_data);
      end
      if (in_valid && !in_stall) begin
        sb.note_element($signed(in_element_value));
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_best_difference, out_no_pair);
      end
      if (cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // The receiver stalls in random bursts while stalls are enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (out_gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Element values lean toward the extremes and small ranges so that ties show up.
  function automatic logic [mdd_pkg::DATA_W-1:0] rand_element();
    case ($urandom_range(0, 7))
      0:       return ELEM_MIN;
      1:       return ELEM_MAX;
      2, 3:    return mdd_pkg::DATA_W'($urandom_range(0, 16)) - mdd_pkg::DATA_W'(8);
      default: return $urandom;
    endcase
  endfunction

  // Offer one element and hold it until the transfer happens.
  task automatic send_element(input logic [mdd_pkg::DATA_W-1:0] x);
    @(negedge clk);
    if (in_gaps_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_element_value <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_element(rand_element());
  endtask

  // Change the matrix side once the core has drained.
  task automatic write_size(input logic [mdd_pkg::CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int                        sent;
    int                        n;
    int                        reps;
    int                        part;
    logic [mdd_pkg::CFG_W-1:0] size_pick;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_element_value = '0;
    in_gaps_on       = 1'b1;
    out_gaps_on      = 1'b1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // A partial matrix at the reset size is dropped by a size write.
    send_random(3);
    write_size(mdd_pkg::CFG_W'(2));

    // Largest and smallest possible differences.
    send_element(ELEM_MIN);
    send_element('0);
    send_element('1);
    send_element(ELEM_MAX);
    send_element(ELEM_MAX);
    send_element(ELEM_MIN);
    send_element(ELEM_MIN);
    send_element(ELEM_MIN);

    // Size zero acts as one, so each element is a matrix with no pair.
    write_size('0);
    send_random(2);
    write_size(mdd_pkg::CFG_W'(1));
    send_element(ELEM_MIN);
    send_element(ELEM_MAX);

    // A constant matrix gives a zero difference.
    write_size(mdd_pkg::CFG_W'(3));
    repeat (9) send_element(mdd_pkg::DATA_W'(5));

    // Full store depth: partial matrices that wrap past the last column, at the
    // largest side and at a side that clamps to it, each dropped by a size write.
    write_size(mdd_pkg::CFG_W'(mdd_pkg::MAX_SIZE));
    send_random(100);
    write_size('1);
    send_random(130);

    // Random sizes, mostly small, with whole matrices and some broken ones.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS * 4 / 5) begin
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
      end
      case ($urandom_range(0, 19))
        0:       size_pick = '0;
        1:       size_pick = mdd_pkg::CFG_W'(1);
        19:      size_pick = mdd_pkg::CFG_W'($urandom_range(9, 16));
        default: size_pick = mdd_pkg::CFG_W'($urandom_range(2, 8));
      endcase
      if (sent == 0) begin
        size_pick = mdd_pkg::SIZE_RESET;
      end
      write_size(size_pick);
      n    = int'(sb.side());
      reps = (n > 8) ? 1 : int'($urandom_range(1, 4));
      repeat (reps) begin
        send_random(n * n);
        sent += n * n;
      end
      if (n > 1 && $urandom_range(0, 5) == 0) begin
        part = int'($urandom_range(1, n * n - 1));
        send_random(part);
        sent += part;
      end
    end

    // Drain, then allow for anything stray before the verdict.
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== matrix_max_dominated_difference_core.f =====
rtl/core/mdd_pkg.sv
rtl/core/mdd_row_mem.sv
rtl/core/mdd_scan.sv
rtl/core/mdd_update.sv
rtl/core/matrix_max_dominated_difference_core.sv
test/testbench.sv
